/* rtl/bhni_pkg.sv */
// Shared types, widths and constants for the Barnes-Hut node interaction kernel.
package bhni_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FIELD_BITS     = 32;
   localparam int ACC_BITS       = 48;
   localparam int THR_BITS       = 16;

   // Square root: 66-bit radicand, 33-bit root, two radicand bits per step
   localparam int RAD_BITS   = 66;
   localparam int ROOT_BITS  = 33;
   localparam int REM_BITS   = 35;
   localparam int SQRT_STEPS = 33;

   // Division: G*m*|d| over r^3, one quotient bit per step
   localparam int KD_BITS   = 96;
   localparam int DEN_BITS  = 99;
   localparam int DIV_STEPS = 48;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OPEN_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAV_SCALE     = 1'b1;

   localparam logic [THR_BITS-1:0]   OPEN_THRESHOLD_RST = 16'd230;
   localparam logic [FIELD_BITS-1:0] GRAV_SCALE_RST     = 32'd1;

   localparam logic [ACC_BITS-1:0] ACC_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [ACC_BITS-1:0] ACC_NEG_MAG = 48'h8000_0000_0000;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] part_x;
      logic signed [FIELD_BITS-1:0] part_y;
      logic signed [FIELD_BITS-1:0] part_z;
      logic signed [FIELD_BITS-1:0] node_x;
      logic signed [FIELD_BITS-1:0] node_y;
      logic signed [FIELD_BITS-1:0] node_z;
      logic [FIELD_BITS-1:0]        node_mass;
      logic [FIELD_BITS-1:0]        cell_width;
      logic                         is_leaf;
   } req_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] acc_x;
      logic signed [ACC_BITS-1:0] acc_y;
      logic signed [ACC_BITS-1:0] acc_z;
      logic                       open_children;
   } rsp_type;

   // Travels alongside the square root
   typedef struct packed {
      logic [2:0]              neg;
      logic [2:0][KD_BITS-1:0] kd;
      logic [FIELD_BITS-1:0]   width;
      logic                    leaf;
   } sqrt_side_type;

   // Travels alongside the divider
   typedef struct packed {
      logic [2:0] neg;
      logic [2:0] ovf;
      logic       zero;
      logic       fail;
      logic       leaf;
   } div_side_type;

endpackage

/* rtl/bhni_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
module bhni_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_v,
   input  logic [bhni_pkg::RAD_BITS-1:0]  in_rad,
   input  bhni_pkg::sqrt_side_type        in_side,
   output logic                           out_v,
   output logic [bhni_pkg::ROOT_BITS-1:0] out_root,
   output bhni_pkg::sqrt_side_type        out_side
);

   localparam int STEPS = bhni_pkg::SQRT_STEPS;
   localparam int RADW  = bhni_pkg::RAD_BITS;
   localparam int ROOTW = bhni_pkg::ROOT_BITS;
   localparam int REMW  = bhni_pkg::REM_BITS;

   logic                    v_ff    [STEPS];
   logic [RADW-1:0]         rad_ff  [STEPS];
   logic [RADW-1:0]         rad_in  [STEPS];
   logic [REMW-1:0]         rem_ff  [STEPS];
   logic [REMW-1:0]         rem_in  [STEPS];
   logic [ROOTW-1:0]        root_ff [STEPS];
   logic [ROOTW-1:0]        root_in [STEPS];
   bhni_pkg::sqrt_side_type side_ff [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic                    v_i;
      logic [RADW-1:0]         rad_i;
      logic [REMW-1:0]         rem_i;
      logic [ROOTW-1:0]        root_i;
      bhni_pkg::sqrt_side_type side_i;
      logic [REMW+1:0]         cur;
      logic [REMW+1:0]         trial;
      logic                    ge;

      if (s == 0) begin : g_first
         assign v_i    = in_v;
         assign rad_i  = in_rad;
         assign rem_i  = '0;
         assign root_i = '0;
         assign side_i = in_side;
      end else begin : g_next
         assign v_i    = v_ff[s-1];
         assign rad_i  = rad_ff[s-1];
         assign rem_i  = rem_ff[s-1];
         assign root_i = root_ff[s-1];
         assign side_i = side_ff[s-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign cur        = {rem_i, rad_i[RADW-1 -: 2]};
      assign trial      = {2'b00, root_i, 2'b01};
      assign ge         = cur >= trial;
      assign rad_in[s]  = {rad_i[RADW-3:0], 2'b00};
      assign rem_in[s]  = ge ? REMW'(cur - trial) : REMW'(cur);
      assign root_in[s] = {root_i[ROOTW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            side_ff[s] <= side_i;
         end
      end
   end

   assign out_v    = v_ff[STEPS-1];
   assign out_root = root_ff[STEPS-1];
   assign out_side = side_ff[STEPS-1];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_v |-> ({1'b0, rem_ff[STEPS-1]} <= {2'b00, out_root, 1'b0}))
      else $error("square root remainder exceeds twice the root");

endmodule

/* rtl/bhni_div.sv */
// Pipelined restoring divider for three numerators over one shared divisor.
module bhni_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   in_v,
   input  logic [bhni_pkg::DEN_BITS-1:0]          in_den,
   input  logic [2:0][bhni_pkg::DEN_BITS-1:0]     in_rem,
   input  bhni_pkg::div_side_type                 in_side,
   output logic                                   out_v,
   output logic [2:0][bhni_pkg::DIV_STEPS-1:0]    out_q,
   output bhni_pkg::div_side_type                 out_side
);

   localparam int STEPS = bhni_pkg::DIV_STEPS;
   localparam int DENW  = bhni_pkg::DEN_BITS;

   logic                   v_ff    [STEPS];
   logic [DENW-1:0]        den_ff  [STEPS];
   logic [DENW-1:0]        rem_ff  [STEPS][3];
   logic [DENW-1:0]        rem_in  [STEPS][3];
   logic [STEPS-1:0]       q_ff    [STEPS][3];
   logic [STEPS-1:0]       q_in    [STEPS][3];
   bhni_pkg::div_side_type side_ff [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic                   v_i;
      logic [DENW-1:0]        den_i;
      logic [DENW-1:0]        rem_i [3];
      logic [STEPS-1:0]       q_i   [3];
      bhni_pkg::div_side_type side_i;

      if (s == 0) begin : g_first
         assign v_i    = in_v;
         assign den_i  = in_den;
         assign side_i = in_side;
         for (genvar a = 0; a < 3; a++) begin : g_ax
            assign rem_i[a] = in_rem[a];
            assign q_i[a]   = '0;
         end
      end else begin : g_next
         assign v_i    = v_ff[s-1];
         assign den_i  = den_ff[s-1];
         assign side_i = side_ff[s-1];
         for (genvar a = 0; a < 3; a++) begin : g_ax
            assign rem_i[a] = rem_ff[s-1][a];
            assign q_i[a]   = q_ff[s-1][a];
         end
      end

      for (genvar a = 0; a < 3; a++) begin : g_lane
         logic [DENW:0] t;
         logic          ge;
         assign t          = {rem_i[a], 1'b0};
         assign ge         = t >= {1'b0, den_i};
         assign rem_in[s][a] = ge ? DENW'(t - {1'b0, den_i}) : t[DENW-1:0];
         assign q_in[s][a]   = {q_i[a][STEPS-2:0], ge};

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s][a] <= rem_in[s][a];
               q_ff[s][a]   <= q_in[s][a];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[s]  <= den_i;
            side_ff[s] <= side_i;
         end
      end
   end

   assign out_v    = v_ff[STEPS-1];
   assign out_side = side_ff[STEPS-1];
   assign out_q    = {q_ff[STEPS-1][2], q_ff[STEPS-1][1], q_ff[STEPS-1][0]};

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (out_v && !out_side.zero && !out_side.ovf[0])
         |-> (rem_ff[STEPS-1][0] < den_ff[STEPS-1]))
      else $error("divider remainder not below divisor");

endmodule

/* rtl/barnes_hut_node_interaction_top.sv */
// Top level of the Barnes-Hut particle/node gravity kernel.
//
// One request beat carries a particle position and a tree node summary
// (centre of mass, mass, cell width, leaf flag); one response beat carries
// the saturated acceleration contribution and the open-children flag.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. The csr_ port writes theta (index 0, Q8.8) and G (index 1);
// write only while no request is in flight.
// Throughput: one request per cycle, back to back, while the response is not stalled.
// A request beat reaches response valid through the 33-stage square root
// and the 48-stage divider for G*m*d/r^3, plus
// eight stages of offsets, products, r^3 and result formatting.
// When the response is stalled the whole pipeline holds and req_stall is
// raised; nothing is dropped or repeated. Reset empties the pipeline and
// loads theta = 230 and G = 1.
module barnes_hut_node_interaction_top #(
   parameter int COORD_BITS = bhni_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bhni_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bhni_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [bhni_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bhni_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CW    = (COORD_BITS < bhni_pkg::FIELD_BITS) ? COORD_BITS
                                                              : bhni_pkg::FIELD_BITS;
   localparam int FW    = bhni_pkg::FIELD_BITS;
   localparam int ROOTW = bhni_pkg::ROOT_BITS;
   localparam int KDW   = bhni_pkg::KD_BITS;
   localparam int DENW  = bhni_pkg::DEN_BITS;
   localparam int ACCW  = bhni_pkg::ACC_BITS;
   localparam int QW    = bhni_pkg::DIV_STEPS;

   function automatic logic signed [FW:0] ext_coord(input logic [FW-1:0] v);
      logic signed [CW-1:0] low;
      low = signed'(v[CW-1:0]);
      return (FW+1)'(low);
   endfunction

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // configuration
   logic [bhni_pkg::THR_BITS-1:0] thr_ff;
   logic [FW-1:0]                 gs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= bhni_pkg::OPEN_THRESHOLD_RST;
         gs_ff  <= bhni_pkg::GRAV_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bhni_pkg::CSR_OPEN_THRESHOLD: thr_ff <= csr_wdata[bhni_pkg::THR_BITS-1:0];
            bhni_pkg::CSR_GRAV_SCALE:     gs_ff  <= csr_wdata[FW-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: offsets and G*m
   logic                 s1_v_ff;
   logic [2:0][FW-1:0]   s1_mag_ff, s1_mag_in;
   logic [2:0]           s1_neg_ff, s1_neg_in;
   logic [2*FW-1:0]      s1_k_ff, s1_k_in;
   logic [FW-1:0]        s1_width_ff;
   logic                 s1_leaf_ff;

   always_comb begin
      logic signed [FW:0] pc [3];
      logic signed [FW:0] nc [3];
      logic signed [FW:0] d;
      logic [FW:0]        m;
      pc[0] = ext_coord(req_data.part_x);
      pc[1] = ext_coord(req_data.part_y);
      pc[2] = ext_coord(req_data.part_z);
      nc[0] = ext_coord(req_data.node_x);
      nc[1] = ext_coord(req_data.node_y);
      nc[2] = ext_coord(req_data.node_z);
      for (int a = 0; a < 3; a++) begin
         d            = nc[a] - pc[a];
         m            = d[FW] ? (FW+1)'(-d) : (FW+1)'(d);
         s1_neg_in[a] = d[FW];
         s1_mag_in[a] = m[FW-1:0];
      end
      s1_k_in = gs_ff * req_data.node_mass;
   end

   // stage 2: squares and partial products of G*m*|d|
   logic                     s2_v_ff;
   logic [2:0][2*FW-1:0]     s2_sq_ff, s2_sq_in;
   logic [2:0][2*FW-1:0]     s2_kdl_ff, s2_kdl_in;
   logic [2:0][2*FW-1:0]     s2_kdh_ff, s2_kdh_in;
   logic [2:0]               s2_neg_ff;
   logic [FW-1:0]            s2_width_ff;
   logic                     s2_leaf_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s2_sq_in[a]  = s1_mag_ff[a] * s1_mag_ff[a];
         s2_kdl_in[a] = s1_k_ff[FW-1:0] * s1_mag_ff[a];
         s2_kdh_in[a] = s1_k_ff[2*FW-1:FW] * s1_mag_ff[a];
      end
   end

   // stage 3: squared distance and full G*m*|d|
   logic                           s3_v_ff;
   logic [bhni_pkg::RAD_BITS-1:0]  s3_sum_ff, s3_sum_in;
   bhni_pkg::sqrt_side_type        s3_side_ff, s3_side_in;

   always_comb begin
      s3_sum_in = bhni_pkg::RAD_BITS'(s2_sq_ff[0]) + bhni_pkg::RAD_BITS'(s2_sq_ff[1])
                + bhni_pkg::RAD_BITS'(s2_sq_ff[2]);
      for (int a = 0; a < 3; a++) begin
         s3_side_in.kd[a] = KDW'(s2_kdl_ff[a]) + {s2_kdh_ff[a], {FW{1'b0}}};
      end
      s3_side_in.neg   = s2_neg_ff;
      s3_side_in.width = s2_width_ff;
      s3_side_in.leaf  = s2_leaf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff   <= s1_mag_in;
         s1_neg_ff   <= s1_neg_in;
         s1_k_ff     <= s1_k_in;
         s1_width_ff <= req_data.cell_width;
         s1_leaf_ff  <= req_data.is_leaf;
         s2_sq_ff    <= s2_sq_in;
         s2_kdl_ff   <= s2_kdl_in;
         s2_kdh_ff   <= s2_kdh_in;
         s2_neg_ff   <= s1_neg_ff;
         s2_width_ff <= s1_width_ff;
         s2_leaf_ff  <= s1_leaf_ff;
         s3_sum_ff   <= s3_sum_in;
         s3_side_ff  <= s3_side_in;
      end
   end

   // distance
   logic                    sq_v;
   logic [ROOTW-1:0]        sq_root;
   bhni_pkg::sqrt_side_type sq_side;

   bhni_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_v     (s3_v_ff),
      .in_rad   (s3_sum_ff),
      .in_side  (s3_side_ff),
      .out_v    (sq_v),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // stage 4: r^2 and the opening test
   logic                      s4_v_ff;
   logic [2*ROOTW-1:0]        s4_r2_ff, s4_r2_in;
   logic [ROOTW-1:0]          s4_r_ff;
   logic                      s4_zero_ff, s4_zero_in;
   logic                      s4_fail_ff, s4_fail_in;
   logic [2:0]                s4_neg_ff;
   logic [2:0][KDW-1:0]       s4_kd_ff;
   logic                      s4_leaf_ff;
   logic [bhni_pkg::THR_BITS+ROOTW-1:0] s4_thr_r;

   always_comb begin
      s4_r2_in   = sq_root * sq_root;
      s4_thr_r   = thr_ff * sq_root;
      s4_fail_in = (bhni_pkg::THR_BITS+ROOTW)'({sq_side.width, 8'h00}) > s4_thr_r;
      s4_zero_in = sq_root == '0;
   end

   // stage 5: r^3 partial products
   logic                  s5_v_ff;
   logic [2*ROOTW-1:0]    s5_plo_ff, s5_plo_in;
   logic [2*ROOTW-1:0]    s5_phi_ff, s5_phi_in;
   logic                  s5_zero_ff, s5_fail_ff, s5_leaf_ff;
   logic [2:0]            s5_neg_ff;
   logic [2:0][KDW-1:0]   s5_kd_ff;

   always_comb begin
      s5_plo_in = s4_r2_ff[ROOTW-1:0] * s4_r_ff;
      s5_phi_in = s4_r2_ff[2*ROOTW-1:ROOTW] * s4_r_ff;
   end

   // stage 6: r^3
   logic                  s6_v_ff;
   logic [DENW-1:0]       s6_r3_ff, s6_r3_in;
   logic                  s6_zero_ff, s6_fail_ff, s6_leaf_ff;
   logic [2:0]            s6_neg_ff;
   logic [2:0][KDW-1:0]   s6_kd_ff;

   assign s6_r3_in = DENW'(s5_plo_ff) + {s5_phi_ff, {ROOTW{1'b0}}};

   // stage 7: saturation check, divider operands
   logic                   s7_v_ff;
   logic [DENW-1:0]        s7_r3_ff;
   logic [2:0][DENW-1:0]   s7_rem_ff, s7_rem_in;
   bhni_pkg::div_side_type s7_side_ff, s7_side_in;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s7_rem_in[a]      = DENW'(s6_kd_ff[a]);
         // quotient would reach 2^48
         s7_side_in.ovf[a] = DENW'(s6_kd_ff[a]) >= s6_r3_ff;
      end
      s7_side_in.neg  = s6_neg_ff;
      s7_side_in.zero = s6_zero_ff;
      s7_side_in.fail = s6_fail_ff;
      s7_side_in.leaf = s6_leaf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= sq_v;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_r2_ff   <= s4_r2_in;
         s4_r_ff    <= sq_root;
         s4_zero_ff <= s4_zero_in;
         s4_fail_ff <= s4_fail_in;
         s4_neg_ff  <= sq_side.neg;
         s4_kd_ff   <= sq_side.kd;
         s4_leaf_ff <= sq_side.leaf;
         s5_plo_ff  <= s5_plo_in;
         s5_phi_ff  <= s5_phi_in;
         s5_zero_ff <= s4_zero_ff;
         s5_fail_ff <= s4_fail_ff;
         s5_leaf_ff <= s4_leaf_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_kd_ff   <= s4_kd_ff;
         s6_r3_ff   <= s6_r3_in;
         s6_zero_ff <= s5_zero_ff;
         s6_fail_ff <= s5_fail_ff;
         s6_leaf_ff <= s5_leaf_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_kd_ff   <= s5_kd_ff;
         s7_r3_ff   <= s6_r3_ff;
         s7_rem_ff  <= s7_rem_in;
         s7_side_ff <= s7_side_in;
      end
   end

   logic                   dv_v;
   logic [2:0][QW-1:0]     dv_q;
   bhni_pkg::div_side_type dv_side;

   bhni_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_v     (s7_v_ff),
      .in_den   (s7_r3_ff),
      .in_rem   (s7_rem_ff),
      .in_side  (s7_side_ff),
      .out_v    (dv_v),
      .out_q    (dv_q),
      .out_side (dv_side)
   );

   // output register: saturate, apply sign, zero the acceleration of opened nodes and of zero distance
   logic              rsp_valid_ff;
   bhni_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      logic [2:0][ACCW-1:0] acc;
      logic [ACCW-1:0]      lim;
      logic [ACCW-1:0]      m;
      logic                 open;
      open = !dv_side.leaf && (dv_side.zero || dv_side.fail);
      for (int a = 0; a < 3; a++) begin
         lim = dv_side.neg[a] ? bhni_pkg::ACC_NEG_MAG : bhni_pkg::ACC_POS_MAX;
         m   = (dv_side.ovf[a] || (dv_q[a] > lim)) ? lim : dv_q[a];
         if (dv_side.zero || open) begin
            acc[a] = '0;
         end else begin
            acc[a] = dv_side.neg[a] ? ACCW'(-m) : m;
         end
      end
      rsp_data_in.acc_x         = signed'(acc[0]);
      rsp_data_in.acc_y         = signed'(acc[1]);
      rsp_data_in.acc_z         = signed'(acc[2]);
      rsp_data_in.open_children = open;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_open_zero_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.open_children)
         |-> (rsp_data_ff.acc_x == '0 && rsp_data_ff.acc_y == '0
              && rsp_data_ff.acc_z == '0))
      else $error("opened node carries nonzero acceleration");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s7_v_ff) && $stable(s4_v_ff) && $stable(s1_v_ff)))
      else $error("pipeline advanced while output was stalled");

endmodule
